// ----- rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared sizes, widths and status codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// pool geometry
	localparam int POOL_PAGES = 8192;
	localparam int PAGE_W     = $clog2(POOL_PAGES);
	localparam int COUNT_W    = 14;

	// bitmap storage: one memory word holds the used bits of WORD_W pages
	localparam int WORD_W     = 64;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int NUM_WORDS  = POOL_PAGES / WORD_W;
	localparam int WADDR_W    = $clog2(NUM_WORDS);

	// summary scan: CHUNK_W summary flags are examined per cycle
	localparam int CHUNK_W    = 16;
	localparam int CHUNK_BW   = $clog2(CHUNK_W);
	localparam int NUM_CHUNKS = NUM_WORDS / CHUNK_W;
	localparam int CHUNK_AW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

	// request operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
	localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

endpackage

// ----- rtl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bitmap_page_allocator_top.sv -----
// Sequence: a free in range reads its bitmap word and clears the bit if it is set,
// and an out-of-range free goes straight to its result; an allocate first runs the
// summary scan, which examines 16 word-full flags per cycle, before one bitmap word read.
// Throughput: one request in flight; the next word is taken once the result is loaded.
// Reset: asynchronous, active low; the bitmap reads as all free through per-word
// valid flags, so no clearing pass is needed and requests are taken straight away.
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// Lowest-free-first page allocator over a bitmap held in a 128 x 64 RAM,
// with a per-word full summary and a pages-in-use counter.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_wr_en,
	input  logic [bpa_pkg::COUNT_W-1:0] cfg_wr_data,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [bpa_pkg::PAGE_W-1:0]  page_index,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [bpa_pkg::PAGE_W-1:0]  granted_index,
	output logic [bpa_pkg::COUNT_W-1:0] used_count
);

	import bpa_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_MODIFY = 3'd2;
	localparam logic [2:0] ST_DONE   = 3'd3;

	localparam logic [COUNT_W-1:0]  POOL_LIM   = COUNT_W'(POOL_PAGES);
	localparam logic [CHUNK_AW-1:0] LAST_CHUNK = CHUNK_AW'(NUM_CHUNKS - 1);
	localparam logic [COUNT_W-1:0]  WORD_ROUND = COUNT_W'(WORD_W - 1);

	logic [2:0]            state_q;
	logic [COUNT_W-1:0]    pool_size_q;
	logic [COUNT_W-1:0]    used_q;
	logic [NUM_WORDS-1:0]  full_q;
	logic [NUM_WORDS-1:0]  word_valid_q;

	logic                  op_q;
	logic [PAGE_W-1:0]     idx_q;
	logic [COUNT_W-1:0]    lim_q;
	logic [WADDR_W:0]      lim_words_q;
	logic [CHUNK_AW-1:0]   chunk_q;
	logic [WADDR_W-1:0]    word_q;
	logic                  rd_valid_s2;

	logic [1:0]            res_status_q;
	logic [PAGE_W-1:0]     res_index_q;

	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [PAGE_W-1:0]     out_index_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic [COUNT_W-1:0]    lim_c;
	logic [COUNT_W-1:0]    lim_round_c;
	logic                  accept_c;

	logic                  ram_we;
	logic [WADDR_W-1:0]    ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic                  ram_re;
	logic [WADDR_W-1:0]    ram_raddr;
	logic [WORD_W-1:0]     ram_rdata;

	logic [CHUNK_W-1:0]    elig_c;
	logic                  elig_any_c;
	logic [CHUNK_BW-1:0]   elig_pos_c;
	logic [WADDR_W-1:0]    scan_word_c;

	logic [WORD_W-1:0]     cur_word_c;
	logic                  zero_any_c;
	logic [BIT_W-1:0]      zero_pos_c;
	logic [PAGE_W-1:0]     grant_c;
	logic                  alloc_ok_c;
	logic                  free_ok_c;
	logic [WORD_W-1:0]     new_word_c;
	logic                  out_free_c;

	// effective pool size and its size in words, rounded up
	assign lim_c       = (pool_size_q > POOL_LIM) ? POOL_LIM : pool_size_q;
	assign lim_round_c = lim_c + WORD_ROUND;
	assign accept_c    = in_valid && in_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_free_c  = !out_valid_q || out_ready;

	// find the lowest word of this chunk that is not full and lies inside the pool
	always_comb begin
		logic [WADDR_W-1:0] wi;
		elig_c     = '0;
		elig_any_c = 1'b0;
		elig_pos_c = '0;
		for (int j = 0; j < CHUNK_W; j++) begin
			wi = {chunk_q, CHUNK_BW'(j)};
			elig_c[j] = !full_q[wi] && ({1'b0, wi} < lim_words_q);
		end
		for (int j = CHUNK_W - 1; j >= 0; j--) begin
			if (elig_c[j]) begin
				elig_any_c = 1'b1;
				elig_pos_c = CHUNK_BW'(j);
			end
		end
	end
	assign scan_word_c = {chunk_q, elig_pos_c};

	// word as stored; a never-written word reads as all free
	assign cur_word_c = rd_valid_s2 ? ram_rdata : '0;

	// lowest free bit of the word just read
	always_comb begin
		zero_any_c = 1'b0;
		zero_pos_c = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!cur_word_c[b]) begin
				zero_any_c = 1'b1;
				zero_pos_c = BIT_W'(b);
			end
		end
	end
	assign grant_c    = {word_q, zero_pos_c};
	assign alloc_ok_c = zero_any_c && ({1'b0, grant_c} < lim_q);
	assign free_ok_c  = cur_word_c[idx_q[BIT_W-1:0]];

	// modified word for write-back
	always_comb begin
		new_word_c = cur_word_c;
		if (op_q == OP_FREE) begin
			new_word_c[idx_q[BIT_W-1:0]] = 1'b0;
		end else begin
			new_word_c[zero_pos_c] = 1'b1;
		end
	end

	// bitmap RAM ports
	assign ram_re    = (accept_c && operation == OP_FREE && {1'b0, page_index} < lim_c)
	                || (state_q == ST_SCAN && elig_any_c);
	assign ram_raddr = (state_q == ST_IDLE) ? page_index[PAGE_W-1:BIT_W] : scan_word_c;
	assign ram_we    = (state_q == ST_MODIFY)
	                && ((op_q == OP_FREE) ? free_ok_c : alloc_ok_c);
	assign ram_waddr = word_q;
	assign ram_wdata = new_word_c;

	bpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_LIM;
		end else if (cfg_wr_en) begin
			pool_size_q <= cfg_wr_data;
		end
	end

	// request sequencer, summary flags and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			full_q       <= '0;
			word_valid_q <= '0;
			chunk_q      <= '0;
			rd_valid_s2  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						chunk_q <= '0;
						if (operation == OP_ALLOC) begin
							state_q <= ST_SCAN;
						end else if ({1'b0, page_index} < lim_c) begin
							rd_valid_s2 <= word_valid_q[page_index[PAGE_W-1:BIT_W]];
							state_q     <= ST_MODIFY;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (elig_any_c) begin
						rd_valid_s2 <= word_valid_q[scan_word_c];
						state_q     <= ST_MODIFY;
					end else if (chunk_q == LAST_CHUNK) begin
						state_q <= ST_DONE;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_MODIFY: begin
					if (ram_we) begin
						word_valid_q[word_q] <= 1'b1;
						full_q[word_q]       <= &new_word_c;
						if (op_q == OP_FREE) begin
							if (used_q != '0) begin
								used_q <= used_q - 1'b1;
							end
						end else begin
							used_q <= used_q + 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and pending result
	always_ff @(posedge clk) begin
		if (accept_c) begin
			op_q         <= operation;
			idx_q        <= page_index;
			lim_q        <= lim_c;
			lim_words_q  <= lim_round_c[COUNT_W-1:BIT_W];
			word_q       <= page_index[PAGE_W-1:BIT_W];
			res_index_q  <= '0;
			res_status_q <= (operation == OP_ALLOC) ? STATUS_NO_FREE : STATUS_BAD_FREE;
		end
		if (state_q == ST_SCAN && elig_any_c) begin
			word_q <= scan_word_c;
		end
		if (state_q == ST_MODIFY && ram_we) begin
			res_status_q <= STATUS_OK;
			if (op_q == OP_ALLOC) begin
				res_index_q <= grant_c;
			end
		end
	end

	// output register: load the result word, hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free_c) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_count_q  <= used_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_index = out_index_q;
	assign used_count    = out_count_q;

endmodule

// ----- dv/bpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker
// Watches the request, result and pool-size ports of the page allocator. Keeps
// its own bitmap, in-use count and pool size, works out the result of every
// accepted request word and compares each accepted result word with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bpa_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bpa_pkg::COUNT_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        operation,
	input  logic [bpa_pkg::PAGE_W-1:0]  page_index,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  status,
	input  logic [bpa_pkg::PAGE_W-1:0]  granted_index,
	input  logic [bpa_pkg::COUNT_W-1:0] used_count,
	output int                          mismatches,
	output int                          pending
);

	import bpa_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic [PAGE_W-1:0]  granted;
		logic [COUNT_W-1:0] count;
	} page_result_t;

	page_result_t       results_due[$];
	page_result_t       got;
	page_result_t       want;
	bit                 page_taken[POOL_PAGES];
	logic [COUNT_W-1:0] pages_in_use;
	logic [COUNT_W-1:0] pool_limit;

	// Apply one request to the shadow bitmap and return the result it gives
	function automatic page_result_t serve_request(logic op, logic [PAGE_W-1:0] idx);
		page_result_t r;
		int           span;
		span      = (pool_limit > POOL_PAGES) ? POOL_PAGES : int'(pool_limit);
		r.granted = '0;
		if (op == OP_ALLOC) begin
			// lowest free page below the effective pool size
			r.status = STATUS_NO_FREE;
			for (int i = 0; i < span; i++) begin
				if (!page_taken[i]) begin
					page_taken[i] = 1'b1;
					pages_in_use  = pages_in_use + 1'b1;
					r.granted     = i[PAGE_W-1:0];
					r.status      = STATUS_OK;
					break;
				end
			end
		end else if (int'(idx) < span && page_taken[idx]) begin
			page_taken[idx] = 1'b0;
			if (pages_in_use != '0)
				pages_in_use = pages_in_use - 1'b1;
			r.status = STATUS_OK;
		end else begin
			// out of range or not allocated: drop the request, keep the state
			r.status = STATUS_BAD_FREE;
		end
		r.count = pages_in_use;
		return r;
	endfunction

	// Track configuration, check result words, then predict new request words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (page_taken[i])
				page_taken[i] = 1'b0;
			pages_in_use = '0;
			pool_limit   = COUNT_W'(POOL_PAGES);
			results_due.delete();
			pending      = 0;
		end else begin
			if (cfg_wr_en)
				pool_limit = cfg_wr_data;
			if (out_valid && out_ready) begin
				got = '{status, granted_index, used_count};
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none outstanding: status %0d index %0d count %0d",
						$time, got.status, got.granted, got.count);
				end else begin
					want = results_due.pop_front();
					if (got.status != want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.granted != want.granted) begin
						mismatches++;
						$display("%0t: granted_index expected %0d actual %0d",
							$time, want.granted, got.granted);
					end
					if (got.count != want.count) begin
						mismatches++;
						$display("%0t: used_count expected %0d actual %0d",
							$time, want.count, got.count);
					end
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(serve_request(operation, page_index));
			pending = results_due.size();
		end
	end

endmodule

// ----- dv/tb_bitmap_page_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_top
// Drives allocate and free request words into the page allocator: a directed
// pass over the corner cases, then random phases at several pool sizes, with
// random idling on both channels and one long result back-pressure stretch.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_top;
	import bpa_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int IDLE_PCT    = 13;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 12;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic [PAGE_W-1:0]  page_index;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [PAGE_W-1:0]  granted_index;
	logic [COUNT_W-1:0] used_count;

	int mismatches;
	int pending;
	int words_sent  = 0;
	int allocs_sent = 0;
	int cycles      = 0;
	bit held        = 1'b0;

	bitmap_page_allocator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.page_index   (page_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_index(granted_index),
		.used_count   (used_count)
	);

	bpa_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.page_index   (page_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_index(granted_index),
		.used_count   (used_count),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #2 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// No idling on either side for a stretch of the run
	function automatic int idle_pct();
		return (words_sent >= 600 && words_sent < 850) ? 0 : IDLE_PCT;
	endfunction

	// Result side: random stalls, and one long hold-off that backs up the block
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && words_sent >= 300) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= idle_pct());
			end
		end
	end

	// Offer one request word and hold it until accepted; entered and left at a falling edge
	task automatic send_word(input logic op, input logic [PAGE_W-1:0] idx);
		while ($urandom_range(0, 99) < idle_pct()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		page_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		if (op == OP_ALLOC)
			allocs_sent++;
		@(negedge clk);
	endtask

	// Drain the block, let it settle, then write the pool size
	task automatic set_pool(input int pages);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= COUNT_W'(pages);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Random mix at one pool size; frees mostly aim at the dense low region
	task automatic run_phase(input int pages, input int n_words, input int alloc_pct);
		int span;
		int hi;
		set_pool(pages);
		span = (pages > POOL_PAGES) ? POOL_PAGES : pages;
		for (int k = 0; k < n_words; k++) begin
			hi = ((span < allocs_sent) ? span : allocs_sent) + 3;
			if (hi > POOL_PAGES - 1)
				hi = POOL_PAGES - 1;
			if ($urandom_range(0, 99) < alloc_pct)
				send_word(OP_ALLOC, PAGE_W'($urandom));
			else if ($urandom_range(0, 99) < 12)
				send_word(OP_FREE, PAGE_W'($urandom));
			else
				send_word(OP_FREE, PAGE_W'($urandom_range(0, hi)));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		operation   = OP_ALLOC;
		page_index  = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: frees of unallocated and top pages, reuse of a freed page
		send_word(OP_FREE, '0);
		send_word(OP_FREE, '1);
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, '0);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, PAGE_W'(1));
		send_word(OP_FREE, PAGE_W'(1));
		send_word(OP_ALLOC, '1);
		send_word(OP_FREE, PAGE_W'('h1555));
		send_word(OP_ALLOC, PAGE_W'('h0aaa));

		// Zero pool: nothing to grant, every free is out of range
		set_pool(0);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, '0);

		// Shrink under allocated pages
		set_pool(2);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, PAGE_W'(2));
		send_word(OP_FREE, '0);
		send_word(OP_ALLOC, '0);

		// Pool size above the page count acts as the full pool
		set_pool((1 << COUNT_W) - 1);
		send_word(OP_ALLOC, '0);
		send_word(OP_FREE, PAGE_W'(3));
		send_word(OP_FREE, PAGE_W'(4));
		send_word(OP_ALLOC, '0);

		// Random phases, one filling past the first summary chunk
		run_phase(POOL_PAGES, 150, 60);
		run_phase(1100, 1100, 98);
		run_phase(1000, 60, 30);
		run_phase(0, 20, 50);
		run_phase(65, 60, 50);
		run_phase(1, 20, 50);
		run_phase((1 << COUNT_W) - 1, 120, 50);
		run_phase(POOL_PAGES, 100, 40);

		// Drain and give the verdict
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- bitmap_page_allocator_top.f -----
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bitmap_page_allocator_top.sv
dv/bpa_checker.sv
dv/tb_bitmap_page_allocator_top.sv
